// ----- hw/rtl/mcop_pkg.sv -----
// Shared types and constants of the moov chunk-offset patcher.
// No dependencies; mcop_parse, mcop_burst and the top level import it.
package mcop_pkg;

   // Width of the arithmetic that checks positions against the atom length.
   localparam int CALC_BITS = 64;

   // Four-character atom types, big-endian.
   localparam logic [31:0] ATOM_STCO = 32'h7374636F;
   localparam logic [31:0] ATOM_CO64 = 32'h636F3634;
   localparam logic [31:0] ATOM_CMOV = 32'h636D6F76;

   // Positions inside the atom and inside a chunk-offset table.
   localparam logic [CALC_BITS-1:0] CMOV_LAST_POS = CALC_BITS'(15);
   localparam logic [CALC_BITS-1:0] TYPE_END_MIN  = CALC_BITS'(7);
   localparam logic [CALC_BITS-1:0] HDR_LAST_OFS  = CALC_BITS'(11);
   localparam logic [CALC_BITS-1:0] HDR_LEN       = CALC_BITS'(12);
   localparam logic [CALC_BITS-1:0] SIZE_MIN      = CALC_BITS'(4);

   // Error codes carried with every single-byte result.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_COMPRESSED = 3'd1;
   localparam logic [2:0] ERR_ATOM_OVER  = 3'd2;
   localparam logic [2:0] ERR_TABLE_OVER = 3'd3;
   localparam logic [2:0] ERR_BAD_SIZE   = 3'd4;

   // Number of output bytes caused by one input byte.
   localparam logic [3:0] RUN_NONE   = 4'd0;
   localparam logic [3:0] RUN_ONE    = 4'd1;
   localparam logic [3:0] RUN_NARROW = 4'd4;
   localparam logic [3:0] RUN_WIDE   = 4'd8;

   // Result run handed from the parser to the output stage.
   // Bytes leave from the top of data, most significant first.
   typedef struct packed {
      logic [3:0]  run_len;
      logic [63:0] data;
      logic [2:0]  err;
   } mcop_run_type;

endpackage

// ----- hw/rtl/mcop_if.sv -----
// Valid/ready channel interfaces for the moov chunk-offset patcher.
// Request channel carries moov bytes, response channel carries patched bytes.
interface mcop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] moov_byte;
   logic       start_flag;

   modport source (output valid, output moov_byte, output start_flag, input ready);
   modport sink   (input valid, input moov_byte, input start_flag, output ready);
endinterface

interface mcop_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] error_code;
   logic       last_in_run;

   modport source (output valid, output out_byte, output error_code,
                   output last_in_run, input ready);
   modport sink   (input valid, input out_byte, input error_code,
                   input last_in_run, output ready);
endinterface

// ----- hw/rtl/mcop_parse.sv -----
// Parse state of the patcher: window match, table header, entry collection.
// Depends on mcop_pkg; commits its next state on every step.
module mcop_parse
   import mcop_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         in_byte,
   input  logic               in_start,
   input  logic [31:0]        moov_length,
   output mcop_run_type       run
);

   localparam int RESUME_BITS = (POSITION_BITS > 33) ? POSITION_BITS : 33;

   localparam logic [1:0] MODE_SCAN   = 2'd0;
   localparam logic [1:0] MODE_HEADER = 2'd1;
   localparam logic [1:0] MODE_PATCH  = 2'd2;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // State registers
   logic [POSITION_BITS-1:0] pos_ff,    pos_in;
   logic [63:0]              win_ff,    win_in;
   logic [1:0]               mode_ff,   mode_in;
   logic                     wide_ff,   wide_in;
   logic [POSITION_BITS-1:0] tstart_ff, tstart_in;
   logic [31:0]              eleft_ff,  eleft_in;
   logic [63:0]              ebuf_ff,   ebuf_in;
   logic [2:0]               eidx_ff,   eidx_in;
   logic [RESUME_BITS-1:0]   resume_ff, resume_in;
   logic [2:0]               serr_ff,   serr_in;

   // State as seen after an optional start-of-atom clear
   logic [POSITION_BITS-1:0] cur_pos;
   logic [63:0]              cur_win;
   logic [1:0]               cur_mode;
   logic                     cur_wide;
   logic [POSITION_BITS-1:0] cur_tstart;
   logic [31:0]              cur_eleft;
   logic [63:0]              cur_ebuf;
   logic [2:0]               cur_eidx;
   logic [RESUME_BITS-1:0]   cur_resume;
   logic [2:0]               cur_serr;

   // Position arithmetic, done modulo 2^CALC_BITS
   logic [CALC_BITS-1:0]     p64;
   logic [POSITION_BITS-1:0] type_pos;
   logic [CALC_BITS-1:0]     i64;
   logic [CALC_BITS-1:0]     size64;
   logic [CALC_BITS-1:0]     len64;
   logic [CALC_BITS-1:0]     table_end;
   logic [CALC_BITS-1:0]     need64;
   logic [31:0]              count;
   logic [31:0]              tag;
   logic                     tag_hit;
   logic [63:0]              patched;
   logic [3:0]               width;

   // Clear parse state on a new atom
   always_comb begin
      if (in_start) begin
         cur_pos    = '0;
         cur_win    = '0;
         cur_mode   = MODE_SCAN;
         cur_wide   = 1'b0;
         cur_tstart = '0;
         cur_eleft  = '0;
         cur_ebuf   = '0;
         cur_eidx   = '0;
         cur_resume = '0;
         cur_serr   = ERR_NONE;
      end else begin
         cur_pos    = pos_ff;
         cur_win    = win_ff;
         cur_mode   = mode_ff;
         cur_wide   = wide_ff;
         cur_tstart = tstart_ff;
         cur_eleft  = eleft_ff;
         cur_ebuf   = ebuf_ff;
         cur_eidx   = eidx_ff;
         cur_resume = resume_ff;
         cur_serr   = serr_ff;
      end
   end

   // Window and position terms shared by the branches below
   assign win_in    = {cur_win[55:0], in_byte};
   assign p64       = CALC_BITS'(cur_pos);
   assign type_pos  = cur_pos - POSITION_BITS'(3);
   assign i64       = CALC_BITS'(type_pos);
   assign tag       = win_in[31:0];
   assign size64    = CALC_BITS'(win_in[63:32]);
   assign len64     = CALC_BITS'(moov_length);
   assign tag_hit   = (tag == ATOM_STCO) || (tag == ATOM_CO64);
   assign table_end = i64 + size64;
   assign count     = {cur_ebuf[23:0], in_byte};
   assign need64    = CALC_BITS'(cur_tstart) + HDR_LEN +
                      (cur_wide ? CALC_BITS'({count, 3'b000})
                                : CALC_BITS'({count, 2'b00}));
   assign width     = cur_wide ? RUN_WIDE : RUN_NARROW;
   assign patched   = {cur_ebuf[55:0], in_byte} + 64'(moov_length);

   // Next state and the result run of this byte
   always_comb begin
      pos_in    = (cur_pos != POS_MAX) ? cur_pos + POSITION_BITS'(1) : cur_pos;
      mode_in   = cur_mode;
      wide_in   = cur_wide;
      tstart_in = cur_tstart;
      eleft_in  = cur_eleft;
      ebuf_in   = cur_ebuf;
      eidx_in   = cur_eidx;
      resume_in = cur_resume;
      serr_in   = cur_serr;

      run.run_len = RUN_ONE;
      run.data    = {in_byte, 56'b0};
      run.err     = cur_serr;

      if (cur_serr != ERR_NONE) begin
         // pass through with the sticky code
      end else if ((p64 == CMOV_LAST_POS) && (tag == ATOM_CMOV)) begin
         serr_in = ERR_COMPRESSED;
         mode_in = MODE_SCAN;
         run.err = ERR_COMPRESSED;
      end else begin
         case (cur_mode)
            MODE_HEADER: begin
               ebuf_in = {32'b0, count};
               if (p64 == CALC_BITS'(cur_tstart) + HDR_LAST_OFS) begin
                  if (need64 > len64) begin
                     serr_in = ERR_TABLE_OVER;
                     mode_in = MODE_SCAN;
                  end else if (count == 32'd0) begin
                     mode_in = MODE_SCAN;
                  end else begin
                     eleft_in = count;
                     ebuf_in  = '0;
                     eidx_in  = '0;
                     mode_in  = MODE_PATCH;
                  end
               end
            end
            MODE_PATCH: begin
               ebuf_in = {cur_ebuf[55:0], in_byte};
               if ({1'b0, cur_eidx} + 4'd1 < width) begin
                  // hold the entry until its last byte
                  eidx_in     = cur_eidx + 3'd1;
                  run.run_len = RUN_NONE;
               end else begin
                  run.run_len = width;
                  run.err     = ERR_NONE;
                  run.data    = cur_wide ? patched : {patched[31:0], 32'b0};
                  ebuf_in     = '0;
                  eidx_in     = '0;
                  eleft_in    = cur_eleft - 32'd1;
                  if (cur_eleft == 32'd1) begin
                     mode_in = MODE_SCAN;
                  end
               end
            end
            default: begin
               // scan for a table type ending at this byte
               if ((p64 >= TYPE_END_MIN) && (i64 + SIZE_MIN < len64) &&
                   (i64 >= CALC_BITS'(cur_resume)) && tag_hit) begin
                  if (size64 < SIZE_MIN) begin
                     serr_in = ERR_BAD_SIZE;
                  end else if (table_end - SIZE_MIN > len64) begin
                     serr_in = ERR_ATOM_OVER;
                  end else begin
                     wide_in   = (tag == ATOM_CO64);
                     tstart_in = type_pos;
                     resume_in = RESUME_BITS'(table_end - CALC_BITS'(3));
                     ebuf_in   = '0;
                     mode_in   = MODE_HEADER;
                  end
               end
            end
         endcase
         run.err = (run.run_len == RUN_ONE) ? serr_in : ERR_NONE;
      end
   end

   // Commit on every consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         win_ff    <= '0;
         mode_ff   <= MODE_SCAN;
         wide_ff   <= 1'b0;
         tstart_ff <= '0;
         eleft_ff  <= '0;
         ebuf_ff   <= '0;
         eidx_ff   <= '0;
         resume_ff <= '0;
         serr_ff   <= ERR_NONE;
      end else if (step) begin
         pos_ff    <= pos_in;
         win_ff    <= win_in;
         mode_ff   <= mode_in;
         wide_ff   <= wide_in;
         tstart_ff <= tstart_in;
         eleft_ff  <= eleft_in;
         ebuf_ff   <= ebuf_in;
         eidx_ff   <= eidx_in;
         resume_ff <= resume_in;
         serr_ff   <= serr_in;
      end
   end

endmodule

// ----- hw/rtl/mcop_burst.sv -----
// Output stage of the patcher: holds one result run and shifts it out a beat at a time.
// Depends on mcop_pkg and the response channel interface.
module mcop_burst
   import mcop_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  mcop_run_type  run,
   output logic          free,
   mcop_rsp_if.source    rsp
);

   logic [3:0]  count_ff, count_in;
   logic [63:0] data_ff,  data_in;
   logic [2:0]  err_ff,   err_in;
   logic        pop;

   assign pop  = rsp.valid && rsp.ready;
   // Take a new run when empty or when the last beat leaves now
   assign free = (count_ff == RUN_NONE) || ((count_ff == RUN_ONE) && rsp.ready);

   assign rsp.valid       = (count_ff != RUN_NONE);
   assign rsp.out_byte    = data_ff[63:56];
   assign rsp.error_code  = err_ff;
   assign rsp.last_in_run = (count_ff == RUN_ONE);

   // Load a run, else advance by one beat on a pop
   always_comb begin
      count_in = count_ff;
      data_in  = data_ff;
      err_in   = err_ff;
      if (load) begin
         count_in = run.run_len;
         data_in  = run.data;
         err_in   = run.err;
      end else if (pop) begin
         count_in = count_ff - 4'd1;
         data_in  = {data_ff[55:0], 8'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RUN_NONE;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      err_ff  <= err_in;
   end

endmodule

// ----- hw/rtl/moov_chunk_offset_patcher.sv -----
// Top level of the moov chunk-offset patcher: input register, parser, output stage.
// Depends on mcop_pkg, the channel interfaces, mcop_parse and mcop_burst.
//
// Feed the bytes of one moov atom on req_ch, with start_flag on its first byte, after
// writing the atom's total length to csr_wr_data. Every byte comes back on rsp_ch,
// except that the offsets of each stco or co64 table come back raised by that length,
// one entry at a time as a run of four or eight beats once its last byte is in. The
// block takes one byte per cycle and gives one beat per cycle while rsp_ch is ready,
// and a byte passes the input register and the output stage on its way out. An entry's
// run drains while the next entry's bytes are collected, so the table body streams at
// full rate; the byte after a table's last entry waits for that run to drain. error_code
// is non-zero and sticky on a compressed atom, an overrun or a bad table size, until
// the next start_flag; patching then stops.
module moov_chunk_offset_patcher
   import mcop_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   mcop_req_if.sink     req_ch,
   mcop_rsp_if.source   rsp_ch
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_start_ff;
   logic [31:0]  moov_length_ff;
   logic         consume;
   logic         burst_free;
   mcop_run_type run;

   // Move the held byte on when its results fit in the output stage
   assign consume      = in_valid_ff && ((run.run_len == RUN_NONE) || burst_free);
   assign req_ch.ready = !in_valid_ff || consume;

   assign in_valid_in = (req_ch.valid && req_ch.ready) ? 1'b1 :
                        (consume ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         moov_length_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            moov_length_ff <= csr_wr_data;
         end
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff  <= req_ch.moov_byte;
         in_start_ff <= req_ch.start_flag;
      end
   end

   mcop_parse #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (consume),
      .in_byte     (in_byte_ff),
      .in_start    (in_start_ff),
      .moov_length (moov_length_ff),
      .run         (run)
   );

   mcop_burst u_burst (
      .clock (clock),
      .reset (reset),
      .load  (consume && (run.run_len != RUN_NONE)),
      .run   (run),
      .free  (burst_free),
      .rsp   (rsp_ch)
   );

endmodule

// ----- hw/rtl/mcop_checker.sv -----
// Port-level checks of the moov chunk-offset patcher's response channel.
// No package dependency; bound to the top level at the end of this file.
module mcop_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_error_code,
   input logic       rsp_last_in_run
);

   // Stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_error_code) && $stable(rsp_last_in_run))
      else $error("response beat changed while stalled");

   // Multi-beat runs are patched entries and carry no error
   a_run_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_in_run |-> rsp_error_code == 3'd0)
      else $error("error code inside an entry run");

   // An entry run continues without a gap
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_in_run |=> rsp_valid)
      else $error("gap inside an entry run");

   // Output stage is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind moov_chunk_offset_patcher mcop_checker u_mcop_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_error_code  (rsp_ch.error_code),
   .rsp_last_in_run (rsp_ch.last_in_run)
);
